[rtl/mahd_pkg.sv]
// Shared types, constants and lookup functions for the MPEG-1 audio header decoder.
package mahd_pkg;

  localparam int NUM_STAGES = 8;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_MPEG1   = 3'd1,
    ST_BAD_LAYER   = 3'd2,
    ST_BAD_BITRATE = 3'd3,
    ST_BAD_SRATE   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    DIV_441 = 2'd0,
    DIV_48  = 2'd1,
    DIV_32  = 2'd2
  } div_sel_t;

  localparam logic [1:0]  LAYER_1 = 2'd1;
  localparam logic [1:0]  LAYER_2 = 2'd2;
  localparam logic [1:0]  LAYER_3 = 2'd3;

  localparam logic [15:0] SR_44100 = 16'd44100;
  localparam logic [15:0] SR_48000 = 16'd48000;
  localparam logic [15:0] SR_32000 = 16'd32000;

  localparam logic [9:0]  BR_SCALE = 10'd1000;

  // Frame-size coefficients (384>>3 and 1152>>3); the CD variants carry an extra
  // factor of ten so that 44100 reduces to a divisor of 441.
  localparam logic [10:0] COEF_L1    = 11'd48;
  localparam logic [10:0] COEF_L2    = 11'd144;
  localparam logic [10:0] COEF_L1_CD = 11'd480;
  localparam logic [10:0] COEF_L2_CD = 11'd1440;

  // Reciprocals scaled by 2^28; the one for 32 is exactly 2^23 and needs 24 bits.
  localparam int          RECIP_SHIFT = 28;
  localparam logic [23:0] RECIP_441   = 24'(268435456 / 441);
  localparam logic [23:0] RECIP_48    = 24'(268435456 / 48);
  localparam logic [23:0] RECIP_32    = 24'(268435456 / 32);

  localparam logic [8:0] RATE_L1 [16] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] RATE_L2 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] RATE_L3 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};

  typedef struct packed {
    status_t     status;
    logic [1:0]  layer;
    logic [18:0] bit_rate;
    logic [15:0] sample_rate;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic [1:0]  emphasis;
    logic [3:0]  header_flags;
    logic [1:0]  channel_count;
    logic [15:0] bytes_per_second;
  } hdr_info_t;

  typedef struct packed {
    logic [8:0]  kbps;
    logic [10:0] coef;
    div_sel_t    dsel;
    logic        unit;
  } align_req_t;

  typedef struct packed {
    hdr_info_t  info;
    align_req_t req;
  } dec_t;

  function automatic logic [8:0] rate_kbps(input logic [1:0] layer, input logic [3:0] idx);
    logic [8:0] r;
    case (layer)
      LAYER_1: begin
        r = RATE_L1[idx];
      end
      LAYER_2: begin
        r = RATE_L2[idx];
      end
      LAYER_3: begin
        r = RATE_L3[idx];
      end
      default: begin
        r = '0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [8:0] div_const(input div_sel_t sel);
    logic [8:0] d;
    case (sel)
      DIV_441: begin
        d = 9'd441;
      end
      DIV_48: begin
        d = 9'd48;
      end
      DIV_32: begin
        d = 9'd32;
      end
      default: begin
        d = 9'd32;
      end
    endcase
    return d;
  endfunction

  function automatic logic [23:0] div_recip(input div_sel_t sel);
    logic [23:0] r;
    case (sel)
      DIV_441: begin
        r = RECIP_441;
      end
      DIV_48: begin
        r = RECIP_48;
      end
      DIV_32: begin
        r = RECIP_32;
      end
      default: begin
        r = RECIP_32;
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/mahd_if.sv]
// Valid/ready channel interfaces for the header decoder input and result items.
interface mahd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;

  modport source (output valid, output header_word, input ready);
  modport sink   (input valid, input header_word, output ready);
endinterface

interface mahd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  layer;
  logic [18:0] bit_rate;
  logic [15:0] sample_rate;
  logic [1:0]  channel_mode;
  logic [1:0]  mode_extension;
  logic [1:0]  emphasis;
  logic [3:0]  header_flags;
  logic [1:0]  channel_count;
  logic [15:0] bytes_per_second;
  logic [10:0] block_align;
  logic [15:0] block_size;

  modport source (output valid, input ready, output status, output layer, output bit_rate,
                  output sample_rate, output channel_mode, output mode_extension,
                  output emphasis, output header_flags, output channel_count,
                  output bytes_per_second, output block_align, output block_size);
  modport sink   (input valid, output ready, input status, input layer, input bit_rate,
                  input sample_rate, input channel_mode, input mode_extension,
                  input emphasis, input header_flags, input channel_count,
                  input bytes_per_second, input block_align, input block_size);
endinterface

[rtl/mpeg1_audio_header_decoder.sv]
// Top level of the MPEG-1 audio frame header decoder pipeline.
//
// Decodes one 32-bit MPEG-1 audio frame header per item (first byte in bits 31..24)
// into status, layer, bitrate, sample rate, mode fields, flags, channel count,
// bytes per second, frame size (block align) and ceil(bytes per second / block align).
// Padding and sync bits are not examined; any failed check (id bit, layer, bitrate
// index, sample rate, in that order) returns its status with every other field zero.
// The block is an eight-stage pipeline with valid bits: stage 0 decodes fields and
// reads the bitrate table, stages 1-3 form the frame size (coefficient multiply,
// reciprocal multiply for the sample-rate divide, remainder correction), and stages
// 4-7 run a restoring divider four quotient bits at a time; stage 7 is the output
// register. One item is taken every cycle while out_chan.ready is high. Each stage
// holds independently, so bubbles collapse and a new item is accepted while a
// finished result waits on out_chan.ready, until all eight stages hold items. No
// state is kept between items and there is no configuration.
module mpeg1_audio_header_decoder (
  input  logic      clk,
  input  logic      rst_n,
  mahd_in_if.sink   in_chan,
  mahd_out_if.source out_chan
);

  localparam int NS = mahd_pkg::NUM_STAGES;

  logic [NS-1:0]       v_r;
  logic [NS-1:0]       v_nxt;
  logic [NS:0]         rdy;

  mahd_pkg::dec_t      dec_r;
  mahd_pkg::hdr_info_t info_r [1:NS-1];
  logic [10:0]         align_r;
  logic [15:0]         quo;
  logic [10:0]         dvs;
  logic                ok;

  // Stage may advance when empty or when its successor advances.
  always_comb begin
    rdy[NS] = out_chan.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    v_nxt[0] = rdy[0] ? in_chan.valid : v_r[0];
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = v_r[k-1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_chan.ready = rdy[0];

  mahd_decode u_decode (
    .clk         (clk),
    .en          (rdy[0]),
    .header_word (in_chan.header_word),
    .dec_r       (dec_r)
  );

  mahd_align u_align (
    .clk     (clk),
    .en      (rdy[3:1]),
    .req     (dec_r.req),
    .align_r (align_r)
  );

  mahd_div u_div (
    .clk   (clk),
    .en    (rdy[7:4]),
    .bps   (info_r[3].bytes_per_second),
    .align (align_r),
    .quo   (quo),
    .dvs   (dvs)
  );

  // Carry the decoded fields alongside the arithmetic stages.
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      info_r[1] <= dec_r.info;
    end
    for (int k = 2; k < NS; k++) begin
      if (rdy[k]) begin
        info_r[k] <= info_r[k-1];
      end
    end
  end

  assign ok = (info_r[NS-1].status == mahd_pkg::ST_OK);

  assign out_chan.valid            = v_r[NS-1];
  assign out_chan.status           = info_r[NS-1].status;
  assign out_chan.layer            = info_r[NS-1].layer;
  assign out_chan.bit_rate         = info_r[NS-1].bit_rate;
  assign out_chan.sample_rate      = info_r[NS-1].sample_rate;
  assign out_chan.channel_mode     = info_r[NS-1].channel_mode;
  assign out_chan.mode_extension   = info_r[NS-1].mode_extension;
  assign out_chan.emphasis         = info_r[NS-1].emphasis;
  assign out_chan.header_flags     = info_r[NS-1].header_flags;
  assign out_chan.channel_count    = info_r[NS-1].channel_count;
  assign out_chan.bytes_per_second = info_r[NS-1].bytes_per_second;
  // Zero the derived sizes on error items.
  assign out_chan.block_align      = ok ? dvs : '0;
  assign out_chan.block_size       = ok ? quo : '0;

  // Error items carry nothing but their status.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !ok |->
      out_chan.bit_rate == '0 && out_chan.block_align == '0 && out_chan.block_size == '0)
    else $error("error item carries nonzero fields");

  // Layer 3 frames have unit align, so block size equals bytes per second.
  a_l3_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && ok && out_chan.layer == mahd_pkg::LAYER_3 |->
      out_chan.block_align == 11'd1 && out_chan.block_size == out_chan.bytes_per_second)
    else $error("layer 3 align or size mismatch");

  // Block size is the ceiling of bytes per second over align.
  a_ceil: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && ok |->
      (27'(out_chan.block_align) * 27'(out_chan.block_size)
         >= 27'(out_chan.bytes_per_second)) &&
      (27'(out_chan.block_align) * 27'(out_chan.block_size - 16'd1)
         < 27'(out_chan.bytes_per_second)))
    else $error("block size is not the ceiling quotient");

  // Bytes per second tracks the bitrate that traveled with it.
  a_bps: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && ok |->
      out_chan.bytes_per_second == 16'(out_chan.bit_rate >> 3))
    else $error("bytes per second does not match bitrate");

endmodule

[rtl/mahd_decode.sv]
// Field extraction, validity checks and bitrate table lookup (first pipeline stage).
module mahd_decode (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        header_word,
  output mahd_pkg::dec_t     dec_r
);

  mahd_pkg::dec_t dec_nxt;

  always_comb begin
    logic [31:0]        w;
    logic [1:0]         layer_v;
    logic [8:0]         kbps_v;
    logic [15:0]        sr_v;
    logic               cd_v;
    mahd_pkg::div_sel_t dsel_v;
    mahd_pkg::status_t  st_v;
    logic [18:0]        br_v;

    w       = header_word;
    layer_v = '0;
    kbps_v  = '0;
    sr_v    = '0;
    cd_v    = 1'b0;
    dsel_v  = mahd_pkg::DIV_32;
    st_v    = mahd_pkg::ST_OK;
    dec_nxt = '0;

    // Checks run in order; the first failure wins.
    if (!w[19]) begin
      st_v = mahd_pkg::ST_NOT_MPEG1;
    end else begin
      case (w[18:17])
        2'b11: begin
          layer_v = mahd_pkg::LAYER_1;
        end
        2'b10: begin
          layer_v = mahd_pkg::LAYER_2;
        end
        2'b01: begin
          layer_v = mahd_pkg::LAYER_3;
        end
        default: begin
          st_v = mahd_pkg::ST_BAD_LAYER;
        end
      endcase
    end

    if (st_v == mahd_pkg::ST_OK) begin
      kbps_v = mahd_pkg::rate_kbps(layer_v, w[15:12]);
      if (kbps_v == '0) begin
        st_v = mahd_pkg::ST_BAD_BITRATE;
      end
    end

    if (st_v == mahd_pkg::ST_OK) begin
      case (w[11:10])
        2'd0: begin
          sr_v   = mahd_pkg::SR_44100;
          dsel_v = mahd_pkg::DIV_441;
          cd_v   = 1'b1;
        end
        2'd1: begin
          sr_v   = mahd_pkg::SR_48000;
          dsel_v = mahd_pkg::DIV_48;
        end
        2'd2: begin
          sr_v   = mahd_pkg::SR_32000;
          dsel_v = mahd_pkg::DIV_32;
        end
        default: begin
          st_v = mahd_pkg::ST_BAD_SRATE;
        end
      endcase
    end

    br_v = 19'(kbps_v) * 19'(mahd_pkg::BR_SCALE);

    dec_nxt.info.status = st_v;
    if (st_v == mahd_pkg::ST_OK) begin
      dec_nxt.info.layer            = layer_v;
      dec_nxt.info.bit_rate         = br_v;
      dec_nxt.info.sample_rate      = sr_v;
      dec_nxt.info.channel_mode     = w[7:6];
      dec_nxt.info.mode_extension   = w[5:4];
      dec_nxt.info.emphasis         = w[1:0];
      dec_nxt.info.header_flags     = {w[2], w[3], w[8], w[16]};
      dec_nxt.info.channel_count    = (w[7:6] == 2'd3) ? 2'd1 : 2'd2;
      dec_nxt.info.bytes_per_second = 16'(br_v >> 3);
      dec_nxt.req.kbps              = kbps_v;
      dec_nxt.req.dsel              = dsel_v;
      dec_nxt.req.unit              = (layer_v == mahd_pkg::LAYER_3);
      case (layer_v)
        mahd_pkg::LAYER_1: begin
          dec_nxt.req.coef = cd_v ? mahd_pkg::COEF_L1_CD : mahd_pkg::COEF_L1;
        end
        mahd_pkg::LAYER_2: begin
          dec_nxt.req.coef = cd_v ? mahd_pkg::COEF_L2_CD : mahd_pkg::COEF_L2;
        end
        default: begin
          dec_nxt.req.coef = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

[rtl/mahd_align.sv]
// Three-stage frame size unit: coefficient product, reciprocal multiply, remainder fix-up.
module mahd_align (
  input  logic                 clk,
  input  logic [2:0]           en,
  input  mahd_pkg::align_req_t req,
  output logic [10:0]          align_r
);

  logic [19:0]        s2_n_r;
  mahd_pkg::div_sel_t s2_dsel_r;
  logic               s2_unit_r;

  logic [14:0]        s3_q_r;
  logic [19:0]        s3_n_r;
  mahd_pkg::div_sel_t s3_dsel_r;
  logic               s3_unit_r;

  logic [19:0]        s2_n_nxt;
  logic [43:0]        s3_prod;
  logic [14:0]        s3_q_nxt;
  logic [10:0]        align_nxt;

  // Numerator: coefficient times kbps.
  assign s2_n_nxt = 20'(req.kbps) * 20'(req.coef);

  // Estimate quotient; low by at most one.
  assign s3_prod  = 44'(s2_n_r) * 44'(mahd_pkg::div_recip(s2_dsel_r));
  assign s3_q_nxt = 15'(s3_prod >> mahd_pkg::RECIP_SHIFT);

  always_comb begin
    logic [19:0] d;
    logic [19:0] rem;
    logic [14:0] q;

    d   = 20'(mahd_pkg::div_const(s3_dsel_r));
    rem = s3_n_r - (20'(s3_q_r) * d);
    q   = s3_q_r;
    if (rem >= d) begin
      q = s3_q_r + 15'd1;
    end
    if (s3_unit_r || (q == '0)) begin
      align_nxt = 11'd1;
    end else begin
      align_nxt = q[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s2_n_r    <= s2_n_nxt;
      s2_dsel_r <= req.dsel;
      s2_unit_r <= req.unit;
    end
    if (en[1]) begin
      s3_q_r    <= s3_q_nxt;
      s3_n_r    <= s2_n_r;
      s3_dsel_r <= s2_dsel_r;
      s3_unit_r <= s2_unit_r;
    end
    if (en[2]) begin
      align_r <= align_nxt;
    end
  end

endmodule

[rtl/mahd_div.sv]
// Four-stage restoring divider, four quotient bits per stage, for ceil(bps / align).
module mahd_div (
  input  logic        clk,
  input  logic [3:0]  en,
  input  logic [15:0] bps,
  input  logic [10:0] align,
  output logic [15:0] quo,
  output logic [10:0] dvs
);

  logic [15:0] nq_r  [4];
  logic [11:0] rem_r [4];
  logic [10:0] dvs_r [4];

  logic [15:0] nq_nxt  [4];
  logic [11:0] rem_nxt [4];
  logic [10:0] dvs_nxt [4];

  // Numerator shifts out of the top of nq while quotient bits shift in at the bottom.
  always_comb begin
    logic [15:0] nq;
    logic [11:0] rem;
    logic [10:0] d;

    for (int s = 0; s < 4; s++) begin
      if (s == 0) begin
        nq  = 16'(17'(bps) + 17'(align) - 17'd1);
        rem = '0;
        d   = align;
      end else begin
        nq  = nq_r[s-1];
        rem = rem_r[s-1];
        d   = dvs_r[s-1];
      end
      for (int b = 0; b < 4; b++) begin
        rem = {rem[10:0], nq[15]};
        nq  = {nq[14:0], 1'b0};
        if (rem >= {1'b0, d}) begin
          rem   = rem - {1'b0, d};
          nq[0] = 1'b1;
        end
      end
      nq_nxt[s]  = nq;
      rem_nxt[s] = rem;
      dvs_nxt[s] = d;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < 4; s++) begin
      if (en[s]) begin
        nq_r[s]  <= nq_nxt[s];
        rem_r[s] <= rem_nxt[s];
        dvs_r[s] <= dvs_nxt[s];
      end
    end
  end

  assign quo = nq_r[3];
  assign dvs = dvs_r[3];

endmodule
